// ----- sv/mma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types, codes and the control program of the matrix multiply block.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int DATA_W        = 16;
  localparam int MAX_DIM_DEF   = 16;
  localparam int DIM_REG_W     = 5;
  localparam int CFG_INDEX_W   = 3;
  localparam int STEP_W        = 4;

  localparam logic [2:0] CMD_LOAD_A  = 3'd0;
  localparam logic [2:0] CMD_LOAD_B  = 3'd1;
  localparam logic [2:0] CMD_LOAD_C  = 3'd2;
  localparam logic [2:0] CMD_COMPUTE = 3'd3;
  localparam logic [2:0] CMD_READ_C  = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_M  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_K = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_N  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BETA    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANS_A = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANS_B = 3'd6;

  localparam logic [STEP_W-1:0] ST_INIT   = 4'd0;
  localparam logic [STEP_W-1:0] ST_RD_C   = 4'd1;
  localparam logic [STEP_W-1:0] ST_SCALE  = 4'd2;
  localparam logic [STEP_W-1:0] ST_SHIFT  = 4'd3;
  localparam logic [STEP_W-1:0] ST_RD_AB  = 4'd4;
  localparam logic [STEP_W-1:0] ST_MUL    = 4'd5;
  localparam logic [STEP_W-1:0] ST_ACC    = 4'd6;
  localparam logic [STEP_W-1:0] ST_ALPHA  = 4'd7;
  localparam logic [STEP_W-1:0] ST_ADD    = 4'd8;
  localparam logic [STEP_W-1:0] ST_WR     = 4'd9;

  typedef struct packed {
    logic [2:0]              cmd;
    logic [3:0]              row;
    logic [3:0]              col;
    logic signed [DATA_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     status;
    logic                     saturated;
  } result_t;

  typedef enum logic [1:0] {
    JMP_NEXT = 2'd0,
    JMP_P    = 2'd1,
    JMP_ELEM = 2'd2
  } jump_t;

  typedef struct packed {
    logic              init;
    logic              rd_c;
    logic              scale;
    logic              shift;
    logic              rd_ab;
    logic              mul;
    logic              acc;
    logic              alpha_mul;
    logic              add;
    logic              wr_c;
    jump_t             jump;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic p_more;
    logic elem_more;
  } seq_flags_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w        = '0;
    w.jump   = JMP_NEXT;
    w.target = ST_INIT;
    case (step)
      ST_INIT:  w.init      = 1'b1;
      ST_RD_C:  w.rd_c      = 1'b1;
      ST_SCALE: w.scale     = 1'b1;
      ST_SHIFT: w.shift     = 1'b1;
      ST_RD_AB: w.rd_ab     = 1'b1;
      ST_MUL:   w.mul       = 1'b1;
      ST_ACC: begin
        w.acc    = 1'b1;
        w.jump   = JMP_P;
        w.target = ST_RD_AB;
      end
      ST_ALPHA: w.alpha_mul = 1'b1;
      ST_ADD:   w.add       = 1'b1;
      ST_WR: begin
        w.wr_c   = 1'b1;
        w.jump   = JMP_ELEM;
        w.target = ST_RD_C;
      end
      default: begin
        w.jump   = JMP_ELEM;
        w.target = ST_INIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- sv/mma_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/mma_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mma_seq
// Microcode sequencer: step counter over the control table, with jumps.
// ----------------------------------------------------------------------------
module mma_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  mma_pkg::seq_flags_t flags,
  output mma_pkg::uword_t    ctrl,
  output logic               running
);

  logic [mma_pkg::STEP_W-1:0] step;
  mma_pkg::uword_t            word;

  assign word = mma_pkg::ucode(step);
  assign ctrl = running ? word : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= mma_pkg::ST_INIT;
    end else if (!running) begin
      if (go) begin
        running <= 1'b1;
        step    <= mma_pkg::ST_INIT;
      end
    end else begin
      unique case (word.jump)
        mma_pkg::JMP_NEXT: step <= step + 1'b1;
        mma_pkg::JMP_P: begin
          step <= flags.p_more ? word.target : step + 1'b1;
        end
        mma_pkg::JMP_ELEM: begin
          if (flags.elem_more) begin
            step <= word.target;
          end else begin
            running <= 1'b0;
            step    <= mma_pkg::ST_INIT;
          end
        end
        default: begin
          running <= 1'b0;
          step    <= mma_pkg::ST_INIT;
        end
      endcase
    end
  end

endmodule

// ----- sv/matrix_multiply_accumulate_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_top
// C = alpha*op(A)*op(B) + beta*C in signed Q8.8, microcoded datapath.
// ----------------------------------------------------------------------------
// Loads, reads and unknown commands are taken whenever busy is low, one per
// cycle, and each gives its result with done high in the following cycle.
// A compute command holds busy high while the control program runs: three
// steps per multiply-accumulate (read A and B, multiply, accumulate) and six
// per element of C; its result appears with done high in the cycle in which
// busy falls. Results are shown for exactly one cycle and cannot be held off.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_top #(
  parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  mma_pkg::item_t                   item,
  output logic                             done,
  output mma_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mma_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mma_pkg::DATA_W-1:0]       cfg_data
);

  localparam int DW      = mma_pkg::DATA_W;
  localparam int DR_W    = mma_pkg::DIM_REG_W;
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CW      = (DIM_W > DR_W) ? DIM_W : DR_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W  = 2 * DW;
  localparam int ACC_W   = PROD_W + IDX_W;
  localparam int APROD_W = DW + ACC_W;
  localparam int SUM_W   = APROD_W - DW + 1;

  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  function automatic logic [CW-1:0] clamp_dim(input logic [DR_W-1:0] r);
    if (r == '0) begin
      return CW'(1);
    end
    if (CW'(r) > CW'(MAX_DIM)) begin
      return CW'(MAX_DIM);
    end
    return CW'(r);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  // configuration
  logic [DR_W-1:0]      rows_m;
  logic [DR_W-1:0]      depth_k;
  logic [DR_W-1:0]      cols_n;
  logic signed [DW-1:0] alpha;
  logic signed [DW-1:0] beta;
  logic                 trans_a;
  logic                 trans_b;

  logic [CW-1:0] m_dim;
  logic [CW-1:0] k_dim;
  logic [CW-1:0] n_dim;

  assign cfg_ready = 1'b1;
  assign m_dim     = clamp_dim(rows_m);
  assign k_dim     = clamp_dim(depth_k);
  assign n_dim     = clamp_dim(cols_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m  <= DR_W'(1);
      depth_k <= DR_W'(1);
      cols_n  <= DR_W'(1);
      alpha   <= DW'(256);
      beta    <= '0;
      trans_a <= 1'b0;
      trans_b <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mma_pkg::REG_ROWS_M:  rows_m  <= cfg_data[DR_W-1:0];
        mma_pkg::REG_DEPTH_K: depth_k <= cfg_data[DR_W-1:0];
        mma_pkg::REG_COLS_N:  cols_n  <= cfg_data[DR_W-1:0];
        mma_pkg::REG_ALPHA:   alpha   <= cfg_data;
        mma_pkg::REG_BETA:    beta    <= cfg_data;
        mma_pkg::REG_TRANS_A: trans_a <= cfg_data[0];
        mma_pkg::REG_TRANS_B: trans_b <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic                accept;
  logic                running;
  mma_pkg::uword_t     ctrl;
  mma_pkg::seq_flags_t flags;

  logic [IDX_W-1:0] i_cnt;
  logic [IDX_W-1:0] j_cnt;
  logic [IDX_W-1:0] p_cnt;
  logic             j_more;

  assign accept          = start && !busy;
  assign busy            = running;
  assign j_more          = (CW'(j_cnt) + CW'(1)) < n_dim;
  assign flags.p_more    = (CW'(p_cnt) + CW'(1)) < k_dim;
  assign flags.elem_more = j_more || ((CW'(i_cnt) + CW'(1)) < m_dim);

  mma_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .go      (accept && (item.cmd == mma_pkg::CMD_COMPUTE)),
    .flags   (flags),
    .ctrl    (ctrl),
    .running (running)
  );

  // item decode
  logic [CW-1:0]     nr;
  logic [CW-1:0]     nc;
  logic              elem_cmd;
  logic              in_range;
  logic [ADDR_W-1:0] item_addr;

  always_comb begin
    nr       = '0;
    nc       = '0;
    elem_cmd = 1'b0;
    unique case (item.cmd)
      mma_pkg::CMD_LOAD_A: begin
        nr       = trans_a ? k_dim : m_dim;
        nc       = trans_a ? m_dim : k_dim;
        elem_cmd = 1'b1;
      end
      mma_pkg::CMD_LOAD_B: begin
        nr       = trans_b ? n_dim : k_dim;
        nc       = trans_b ? k_dim : n_dim;
        elem_cmd = 1'b1;
      end
      mma_pkg::CMD_LOAD_C, mma_pkg::CMD_READ_C: begin
        nr       = m_dim;
        nc       = n_dim;
        elem_cmd = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_range  = (CW'(item.row) < nr) && (CW'(item.col) < nc);
  assign item_addr = cell_addr(IDX_W'(item.row), IDX_W'(item.col));

  // stores
  logic [ADDR_W-1:0] a_raddr;
  logic [ADDR_W-1:0] b_raddr;
  logic [ADDR_W-1:0] c_raddr;
  logic [ADDR_W-1:0] c_waddr;
  logic [DW-1:0]     a_rdata;
  logic [DW-1:0]     b_rdata;
  logic [DW-1:0]     c_rdata;
  logic [DW-1:0]     c_wdata;
  logic              a_we;
  logic              b_we;
  logic              c_we;
  logic              load_ok;
  logic              wr_sat;
  logic signed [SUM_W-1:0] sum;

  assign load_ok = accept && elem_cmd && in_range;
  assign a_we    = load_ok && (item.cmd == mma_pkg::CMD_LOAD_A);
  assign b_we    = load_ok && (item.cmd == mma_pkg::CMD_LOAD_B);
  assign a_raddr = trans_a ? cell_addr(p_cnt, i_cnt) : cell_addr(i_cnt, p_cnt);
  assign b_raddr = trans_b ? cell_addr(j_cnt, p_cnt) : cell_addr(p_cnt, j_cnt);
  assign c_raddr = running ? cell_addr(i_cnt, j_cnt) : item_addr;
  assign c_we    = ctrl.wr_c || (load_ok && (item.cmd == mma_pkg::CMD_LOAD_C));
  assign c_waddr = running ? cell_addr(i_cnt, j_cnt) : item_addr;

  assign wr_sat  = !((&sum[SUM_W-1:DW-1]) || !(|sum[SUM_W-1:DW-1]));
  assign c_wdata = !running ? item.value :
                   wr_sat   ? (sum[SUM_W-1] ? SAT_MIN : SAT_MAX) : sum[DW-1:0];

  mma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (item_addr),
    .wdata (item.value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (item_addr),
    .wdata (item.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  mma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // datapath
  logic signed [PROD_W-1:0]      cprod;
  logic signed [DW-1:0]          cscaled;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [APROD_W-1:0]     aprod;
  logic                          c_sat;
  logic signed [DW-1:0]          c_shifted;
  logic signed [APROD_W-DW-1:0]  a_shifted;
  logic                          flag;

  assign c_sat     = !((&cprod[PROD_W-1:DW+7]) || !(|cprod[PROD_W-1:DW+7]));
  assign c_shifted = c_sat ? (cprod[PROD_W-1] ? SAT_MIN : SAT_MAX) : cprod[DW+7:8];
  assign a_shifted = aprod[APROD_W-1:DW];

  always_ff @(posedge clk) begin
    if (ctrl.rd_c) begin
      acc <= '0;
    end else if (ctrl.acc) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (ctrl.scale) begin
      cprod <= $signed(c_rdata) * beta;
    end
    if (ctrl.shift) begin
      cscaled <= (beta == '0) ? '0 : c_shifted;
    end
    if (ctrl.mul) begin
      prod <= $signed(a_rdata) * $signed(b_rdata);
    end
    if (ctrl.alpha_mul) begin
      aprod <= alpha * acc;
    end
    if (ctrl.add) begin
      sum <= {{(SUM_W-DW){cscaled[DW-1]}}, cscaled} + {a_shifted[APROD_W-DW-1], a_shifted};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt <= '0;
      j_cnt <= '0;
      p_cnt <= '0;
      flag  <= 1'b0;
    end else begin
      if (ctrl.init) begin
        i_cnt <= '0;
        j_cnt <= '0;
        flag  <= 1'b0;
      end
      if (ctrl.rd_c) begin
        p_cnt <= '0;
      end else if (ctrl.acc && flags.p_more) begin
        p_cnt <= p_cnt + 1'b1;
      end
      if (ctrl.shift && (beta != '0) && c_sat) begin
        flag <= 1'b1;
      end
      if (ctrl.wr_c) begin
        if (wr_sat) begin
          flag <= 1'b1;
        end
        if (j_more) begin
          j_cnt <= j_cnt + 1'b1;
        end else begin
          j_cnt <= '0;
          i_cnt <= i_cnt + 1'b1;
        end
      end
    end
  end

  // result
  logic pend_read;
  logic res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      pend_read  <= 1'b0;
      res_status <= 1'b0;
    end else begin
      done       <= 1'b0;
      pend_read  <= 1'b0;
      res_status <= 1'b0;
      if (accept && (item.cmd != mma_pkg::CMD_COMPUTE)) begin
        done       <= 1'b1;
        pend_read  <= in_range && (item.cmd == mma_pkg::CMD_READ_C);
        res_status <= elem_cmd && !in_range;
      end else if (ctrl.wr_c && !flags.elem_more) begin
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    result.read_value = pend_read ? $signed(c_rdata) : '0;
    result.status     = res_status;
    result.saturated  = flag;
  end

endmodule

// ----- tb/sv/tb_matrix_multiply_accumulate_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_accumulate_top
// Self-checking bench for the Q8.8 matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
// A short directed table checks loads, reads, reserved commands, out-of-shape
// accesses and saturating computes right after reset. Random phases follow:
// each drains the block, rewrites every register (sizes at and beyond the
// limits, extreme scale factors, both orientations), fills the operands that
// a compute needs, computes and reads C back, with noise items mixed in.
// Each result is checked field by field against the table's expectation or a
// local predictor, with random gaps on the command and register channels.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_accumulate_top;

  localparam int PERIOD       = 20;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 530;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam logic [mma_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    mma_pkg::item_t   it;
    bit               chk;
    mma_pkg::result_t want;
  } step_row_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            start     = 1'b0;
  mma_pkg::item_t                  item      = '0;
  logic                            cfg_valid = 1'b0;
  logic [mma_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mma_pkg::DATA_W-1:0]      cfg_data  = '0;
  logic                            busy;
  logic                            done;
  logic                            cfg_ready;
  mma_pkg::result_t                result;

  // predictor state
  logic [4:0]         rows_cfg    = 5'd1;
  logic [4:0]         depth_cfg   = 5'd1;
  logic [4:0]         cols_cfg    = 5'd1;
  logic signed [15:0] alpha_cfg   = 16'sd256;
  logic signed [15:0] beta_cfg    = 16'sd0;
  logic               trans_a_cfg = 1'b0;
  logic               trans_b_cfg = 1'b0;
  bit                 sat_flag    = 1'b0;
  logic signed [15:0] a_mem [256];
  logic signed [15:0] b_mem [256];
  logic signed [15:0] c_mem [256];
  bit                 a_set [256];
  bit                 b_set [256];
  bit                 c_set [256];

  mma_pkg::result_t pending_results[$];
  int      errors      = 0;
  int      sent_items  = 0;
  int      idle_cycles = 0;
  bit      no_idle     = 1'b0;

  matrix_multiply_accumulate_top uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #(PERIOD / 2) clk = ~clk;
  end

  function automatic int unsigned eff_dim(input logic [4:0] r);
    if (r == 0) return 1;
    if (r > mma_pkg::MAX_DIM_DEF) return mma_pkg::MAX_DIM_DEF;
    return r;
  endfunction

  function automatic bit in_shape(input logic [2:0] cmd, input logic [3:0] row,
                                  input logic [3:0] col);
    int unsigned m, k, n, nr, nc;
    m  = eff_dim(rows_cfg);
    k  = eff_dim(depth_cfg);
    n  = eff_dim(cols_cfg);
    nr = 0;
    nc = 0;
    case (cmd)
      mma_pkg::CMD_LOAD_A: begin
        nr = trans_a_cfg ? k : m;
        nc = trans_a_cfg ? m : k;
      end
      mma_pkg::CMD_LOAD_B: begin
        nr = trans_b_cfg ? n : k;
        nc = trans_b_cfg ? k : n;
      end
      mma_pkg::CMD_LOAD_C, mma_pkg::CMD_READ_C: begin
        nr = m;
        nc = n;
      end
      default: ;
    endcase
    return (row < nr) && (col < nc);
  endfunction

  function automatic longint clamp_q88(input longint x);
    if (x > 32767) begin
      sat_flag = 1'b1;
      return 32767;
    end
    if (x < -32768) begin
      sat_flag = 1'b1;
      return -32768;
    end
    return x;
  endfunction

  function automatic void run_gemm();
    int unsigned m, k, n;
    longint      acc, dot, av, bv, al, be;
    int          idx;
    m  = eff_dim(rows_cfg);
    k  = eff_dim(depth_cfg);
    n  = eff_dim(cols_cfg);
    al = alpha_cfg;
    be = beta_cfg;
    sat_flag = 1'b0;
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        idx = i * mma_pkg::MAX_DIM_DEF + j;
        acc = c_mem[idx];
        if (be == 0) acc = 0;
        else acc = clamp_q88((acc * be) >>> 8);
        dot = 0;
        for (int p = 0; p < k; p++) begin
          av  = trans_a_cfg ? a_mem[p * mma_pkg::MAX_DIM_DEF + i]
                            : a_mem[i * mma_pkg::MAX_DIM_DEF + p];
          bv  = trans_b_cfg ? b_mem[j * mma_pkg::MAX_DIM_DEF + p]
                            : b_mem[p * mma_pkg::MAX_DIM_DEF + j];
          dot = dot + av * bv;
        end
        c_mem[idx] = 16'(clamp_q88(acc + ((al * dot) >>> 16)));
        c_set[idx] = 1'b1;
      end
    end
  endfunction

  function automatic mma_pkg::result_t gemm_predict(input mma_pkg::item_t it);
    mma_pkg::result_t r;
    logic [7:0]       idx;
    r   = '0;
    idx = {it.row, it.col};
    case (it.cmd)
      mma_pkg::CMD_COMPUTE: run_gemm();
      mma_pkg::CMD_LOAD_A, mma_pkg::CMD_LOAD_B, mma_pkg::CMD_LOAD_C,
      mma_pkg::CMD_READ_C: begin
        if (!in_shape(it.cmd, it.row, it.col)) begin
          r.status = 1'b1;
        end else begin
          case (it.cmd)
            mma_pkg::CMD_LOAD_A: begin
              a_mem[idx] = it.value;
              a_set[idx] = 1'b1;
            end
            mma_pkg::CMD_LOAD_B: begin
              b_mem[idx] = it.value;
              b_set[idx] = 1'b1;
            end
            mma_pkg::CMD_LOAD_C: begin
              c_mem[idx] = it.value;
              c_set[idx] = 1'b1;
            end
            default: r.read_value = c_mem[idx];
          endcase
        end
      end
      default: ;
    endcase
    r.saturated = sat_flag;
    return r;
  endfunction

  function automatic void apply_reg(input logic [mma_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [mma_pkg::DATA_W-1:0] data);
    case (idx)
      mma_pkg::REG_ROWS_M:  rows_cfg    = data[4:0];
      mma_pkg::REG_DEPTH_K: depth_cfg   = data[4:0];
      mma_pkg::REG_COLS_N:  cols_cfg    = data[4:0];
      mma_pkg::REG_ALPHA:   alpha_cfg   = data;
      mma_pkg::REG_BETA:    beta_cfg    = data;
      mma_pkg::REG_TRANS_A: trans_a_cfg = data[0];
      mma_pkg::REG_TRANS_B: trans_b_cfg = data[0];
      default: ;
    endcase
  endfunction

  function automatic mma_pkg::item_t make_item(input logic [2:0] cmd,
                                               input logic [3:0] row,
                                               input logic [3:0] col,
                                               input logic [15:0] value);
    mma_pkg::item_t it;
    it.cmd   = cmd;
    it.row   = row;
    it.col   = col;
    it.value = value;
    return it;
  endfunction

  function automatic step_row_t drow(input logic [2:0] cmd, input logic [3:0] row,
                                     input logic [3:0] col, input logic [15:0] value,
                                     input bit chk, input logic [15:0] rv,
                                     input logic st, input logic sat);
    step_row_t s;
    s.it              = make_item(cmd, row, col, value);
    s.chk             = chk;
    s.want.read_value = rv;
    s.want.status     = st;
    s.want.saturated  = sat;
    return s;
  endfunction

  function automatic int gap_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0100;
        endcase
      end
      2, 3, 4, 5: return 16'($urandom_range(0, 2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h0100;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'hFF00;
      5, 6: return 16'($urandom_range(0, 640)) - 16'd320;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drive_item(input mma_pkg::item_t it, input bit chk,
                            input mma_pkg::result_t want);
    int               gap;
    mma_pkg::result_t pred;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    pred = gemm_predict(it);
    pending_results.push_back(chk ? want : pred);
    sent_items++;
  endtask

  task automatic write_reg(input logic [mma_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [mma_pkg::DATA_W-1:0] data);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  task automatic send_noise(input int count);
    mma_pkg::item_t it;
    repeat (count) begin
      it = make_item(mma_pkg::CMD_READ_C, 4'($urandom), 4'($urandom), rand_value());
      case ($urandom_range(0, 5))
        0: it.cmd = mma_pkg::CMD_LOAD_A;
        1: it.cmd = mma_pkg::CMD_LOAD_B;
        2: it.cmd = mma_pkg::CMD_LOAD_C;
        5: it.cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        default: ;
      endcase
      // never read a C entry that holds no data yet
      if (it.cmd == mma_pkg::CMD_READ_C && in_shape(it.cmd, it.row, it.col) &&
          !c_set[{it.row, it.col}])
        it.cmd = mma_pkg::CMD_LOAD_C;
      drive_item(it, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int ph);
    logic [4:0]                      dm, dk, dn;
    logic [15:0]                     al, be, data;
    logic                            t_a, t_b;
    logic [mma_pkg::CFG_INDEX_W-1:0] ridx;
    logic [3:0]                      r4, c4;
    int unsigned                     m, k, n, s0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    no_idle = ($urandom_range(0, 3) == 0);
    case (ph)
      0: begin
        dm = 5'd16; dk = 5'd1; dn = 5'd1; al = 16'h7FFF; be = 16'h8000; t_a = 1'b1; t_b = 1'b0;
      end
      1: begin
        dm = 5'd1; dk = 5'd16; dn = 5'd1; al = 16'h8000; be = 16'h7FFF; t_a = 1'b0; t_b = 1'b1;
      end
      2: begin
        dm = 5'd1; dk = 5'd1; dn = 5'd16; al = 16'h0100; be = 16'h0100; t_a = 1'b1; t_b = 1'b1;
      end
      3: begin
        dm = 5'd0; dk = 5'd31; dn = 5'd0; al = 16'h0000; be = 16'hFF00; t_a = 1'b0; t_b = 1'b0;
      end
      4: begin
        dm = 5'd2; dk = 5'd3; dn = 5'd2; al = rand_scale(); be = 16'h0100;
        t_a = 1'($urandom); t_b = 1'($urandom);
      end
      default: begin
        dm = 5'($urandom_range(1, 3));
        dk = 5'($urandom_range(1, 3));
        dn = 5'($urandom_range(1, 3));
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 2))
            0: dm = 5'($urandom_range(0, 31));
            1: dk = 5'($urandom_range(0, 31));
            default: dn = 5'($urandom_range(0, 31));
          endcase
        end
        al  = rand_scale();
        be  = rand_scale();
        t_a = 1'($urandom);
        t_b = 1'($urandom);
      end
    endcase
    s0 = $urandom_range(0, 6);
    for (int s = 0; s < 7; s++) begin
      ridx = mma_pkg::CFG_INDEX_W'((s0 + s) % 7);
      case (ridx)
        mma_pkg::REG_ROWS_M:  data = {($urandom_range(0, 1) ? 11'($urandom) : 11'd0), dm};
        mma_pkg::REG_DEPTH_K: data = {($urandom_range(0, 1) ? 11'($urandom) : 11'd0), dk};
        mma_pkg::REG_COLS_N:  data = {($urandom_range(0, 1) ? 11'($urandom) : 11'd0), dn};
        mma_pkg::REG_ALPHA:   data = al;
        mma_pkg::REG_BETA:    data = be;
        mma_pkg::REG_TRANS_A: data = {($urandom_range(0, 1) ? 15'($urandom) : 15'd0), t_a};
        default:              data = {($urandom_range(0, 1) ? 15'($urandom) : 15'd0), t_b};
      endcase
      write_reg(ridx, data);
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;

    m = eff_dim(rows_cfg);
    k = eff_dim(depth_cfg);
    n = eff_dim(cols_cfg);
    send_noise($urandom_range(0, 5));

    // fill every operand the compute reads, refresh some of the rest
    for (int i = 0; i < m; i++) begin
      for (int p = 0; p < k; p++) begin
        r4 = 4'(trans_a_cfg ? p : i);
        c4 = 4'(trans_a_cfg ? i : p);
        if (!a_set[{r4, c4}] || $urandom_range(0, 2) == 0)
          drive_item(make_item(mma_pkg::CMD_LOAD_A, r4, c4, rand_value()), 1'b0, '0);
      end
    end
    for (int p = 0; p < k; p++) begin
      for (int j = 0; j < n; j++) begin
        r4 = 4'(trans_b_cfg ? j : p);
        c4 = 4'(trans_b_cfg ? p : j);
        if (!b_set[{r4, c4}] || $urandom_range(0, 2) == 0)
          drive_item(make_item(mma_pkg::CMD_LOAD_B, r4, c4, rand_value()), 1'b0, '0);
      end
    end
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!c_set[{4'(i), 4'(j)}] || $urandom_range(0, 2) == 0)
          drive_item(make_item(mma_pkg::CMD_LOAD_C, 4'(i), 4'(j), rand_value()), 1'b0, '0);
      end
    end

    if ($urandom_range(0, 2) == 0) drain_results();
    repeat ($urandom_range(1, 2)) begin
      drive_item(make_item(mma_pkg::CMD_COMPUTE, 4'($urandom), 4'($urandom),
                           16'($urandom)), 1'b0, '0);
      if ($urandom_range(0, 3) == 0) send_noise(1);
    end
    repeat ($urandom_range(1, 6)) begin
      drive_item(make_item(mma_pkg::CMD_READ_C, 4'($urandom_range(0, m - 1)),
                           4'($urandom_range(0, n - 1)), 16'($urandom)), 1'b0, '0);
    end
    send_noise($urandom_range(0, 4));
  endtask

  always @(posedge clk) begin
    mma_pkg::result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: got %h", $time, result);
      end else begin
        want = pending_results.pop_front();
        if (result.read_value !== want.read_value) begin
          errors++;
          $display("%0t: read_value expected %h got %h", $time, want.read_value,
                   result.read_value);
        end
        if (result.status !== want.status) begin
          errors++;
          $display("%0t: status expected %b got %b", $time, want.status, result.status);
        end
        if (result.saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated expected %b got %b", $time, want.saturated,
                   result.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    step_row_t rows[$];
    int        ph;
    // reset shape is 1 by 1 by 1, alpha 1.0, beta 0
    rows.push_back(drow(mma_pkg::CMD_READ_C,  4'd0,  4'd1,  16'h0000, 1, 16'h0000, 1'b1, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_LOAD_A,  4'd1,  4'd0,  16'h1234, 1, 16'h0000, 1'b1, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_LOAD_B,  4'd0,  4'd1,  16'h1234, 1, 16'h0000, 1'b1, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_LOAD_C,  4'd15, 4'd15, 16'hFFFF, 1, 16'h0000, 1'b1, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_LOAD_A,  4'd0,  4'd0,  16'h7FFF, 1, 16'h0000, 1'b0, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_LOAD_B,  4'd0,  4'd0,  16'h7FFF, 1, 16'h0000, 1'b0, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_LOAD_C,  4'd0,  4'd0,  16'h8000, 1, 16'h0000, 1'b0, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_READ_C,  4'd0,  4'd0,  16'h0000, 1, 16'h8000, 1'b0, 1'b0));
    rows.push_back(drow(CMD_RSVD_LO,          4'd0,  4'd0,  16'hFFFF, 1, 16'h0000, 1'b0, 1'b0));
    rows.push_back(drow(CMD_RSVD_HI,          4'd15, 4'd15, 16'hFFFF, 1, 16'h0000, 1'b0, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_COMPUTE, 4'd0,  4'd0,  16'h0000, 1, 16'h0000, 1'b0, 1'b1));
    rows.push_back(drow(mma_pkg::CMD_READ_C,  4'd0,  4'd0,  16'h0000, 1, 16'h7FFF, 1'b0, 1'b1));
    rows.push_back(drow(CMD_RSVD_LO + 3'd1,   4'd5,  4'd9,  16'h5A5A, 1, 16'h0000, 1'b0, 1'b1));
    rows.push_back(drow(mma_pkg::CMD_READ_C,  4'd15, 4'd0,  16'h0000, 1, 16'h0000, 1'b1, 1'b1));
    rows.push_back(drow(mma_pkg::CMD_LOAD_A,  4'd0,  4'd0,  16'h0100, 1, 16'h0000, 1'b0, 1'b1));
    rows.push_back(drow(mma_pkg::CMD_LOAD_B,  4'd0,  4'd0,  16'hFF00, 1, 16'h0000, 1'b0, 1'b1));
    rows.push_back(drow(mma_pkg::CMD_COMPUTE, 4'd0,  4'd0,  16'h0000, 0, 16'h0000, 1'b0, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_READ_C,  4'd0,  4'd0,  16'h0000, 0, 16'h0000, 1'b0, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_LOAD_A,  4'd0,  4'd0,  16'h8000, 1, 16'h0000, 1'b0, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_LOAD_B,  4'd0,  4'd0,  16'h8000, 1, 16'h0000, 1'b0, 1'b0));
    rows.push_back(drow(mma_pkg::CMD_COMPUTE, 4'd0,  4'd0,  16'h0000, 1, 16'h0000, 1'b0, 1'b1));
    rows.push_back(drow(mma_pkg::CMD_READ_C,  4'd0,  4'd0,  16'h0000, 1, 16'h7FFF, 1'b0, 1'b1));
    rows.push_back(drow(mma_pkg::CMD_LOAD_B,  4'd0,  4'd0,  16'h7FFF, 1, 16'h0000, 1'b0, 1'b1));
    rows.push_back(drow(mma_pkg::CMD_COMPUTE, 4'd0,  4'd0,  16'h0000, 1, 16'h0000, 1'b0, 1'b1));
    rows.push_back(drow(mma_pkg::CMD_READ_C,  4'd0,  4'd0,  16'h0000, 1, 16'h8000, 1'b0, 1'b1));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    foreach (rows[i]) drive_item(rows[i].it, rows[i].chk, rows[i].want);

    sent_items = 0;
    ph = 0;
    while (sent_items < RANDOM_ITEMS) begin
      run_phase(ph);
      ph++;
    end
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
